// ===== rtl/core/bmp24_to_rgb565_stream_core_defines.svh =====
// ---------------------------------------------------------------------------
// BMP565 assertion macros
// Shared helpers for the concurrent checks of the BMP stream decoder.
// ---------------------------------------------------------------------------
`ifndef BMP24_TO_RGB565_STREAM_CORE_DEFINES_SVH
`define BMP24_TO_RGB565_STREAM_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BMP565_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BMP565_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bmp565_pkg.sv =====
// ---------------------------------------------------------------------------
// BMP565 package
// Types and fixed constants of the 24-bit BMP to RGB565 stream decoder.
// ---------------------------------------------------------------------------
package bmp565_pkg;

  localparam int unsigned PIX_BITS    = 12;
  localparam int unsigned SCREEN_BITS = 13;

  localparam logic [15:0] BMP_SIGNATURE = 16'h4D42;
  localparam logic [15:0] BMP_PLANES    = 16'd1;
  localparam logic [15:0] BMP_DEPTH     = 16'd24;
  localparam logic [SCREEN_BITS-1:0] SCREEN_MAX = 13'd4096;
  localparam logic [31:0] HDR_BYTES     = 32'd34;

  // Positions of the header bytes that complete a field; IDX_ORIGIN marks the first byte.
  localparam logic [5:0] IDX_ORIGIN = 6'd0;
  localparam logic [5:0] IDX_SIG    = 6'd1;
  localparam logic [5:0] IDX_OFFSET = 6'd13;
  localparam logic [5:0] IDX_WIDTH  = 6'd21;
  localparam logic [5:0] IDX_HEIGHT = 6'd25;
  localparam logic [5:0] IDX_PLANES = 6'd27;
  localparam logic [5:0] IDX_DEPTH  = 6'd29;
  localparam logic [5:0] IDX_COMPR  = 6'd33;

  localparam logic [1:0] CFG_X_ORIGIN      = 2'd0;
  localparam logic [1:0] CFG_Y_ORIGIN      = 2'd1;
  localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd3;

  typedef enum logic [1:0] {
    KIND_PIXEL      = 2'd0,
    KIND_BAD_SIG    = 2'd1,
    KIND_BAD_FORMAT = 2'd2,
    KIND_OFF_SCREEN = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_SKIP   = 5'b00010,
    PH_PIXEL  = 5'b00100,
    PH_PAD    = 5'b01000,
    PH_IDLE   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [15:0]            x_origin;
    logic [15:0]            y_origin;
    logic [SCREEN_BITS-1:0] screen_width;
    logic [SCREEN_BITS-1:0] screen_height;
  } cfg_t;

  typedef struct packed {
    kind_t               kind;
    logic [PIX_BITS-1:0] pixel_x;
    logic [PIX_BITS-1:0] pixel_y;
    logic [15:0]         color;
    logic                image_done;
  } result_t;

  function automatic logic [15:0] rgb565(input logic [7:0] blue, input logic [7:0] green,
                                         input logic [7:0] red);
    rgb565 = {red[7:3], green[7:2], blue[7:3]};
  endfunction

endpackage

// ===== rtl/core/bmp565_cfg.sv =====
// ---------------------------------------------------------------------------
// BMP565 configuration registers
// Holds origin and screen size and clamps the screen size to 4096.
// ---------------------------------------------------------------------------
module bmp565_cfg
  import bmp565_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  logic [15:0]            x_origin;
  logic [15:0]            y_origin;
  logic [SCREEN_BITS-1:0] screen_width;
  logic [SCREEN_BITS-1:0] screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_origin      <= '0;
      y_origin      <= '0;
      screen_width  <= 13'd320;
      screen_height <= 13'd240;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_X_ORIGIN:      x_origin      <= cfg_data;
        CFG_Y_ORIGIN:      y_origin      <= cfg_data;
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data[SCREEN_BITS-1:0];
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data[SCREEN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.x_origin      = x_origin;
    cfg.y_origin      = y_origin;
    cfg.screen_width  = (screen_width > SCREEN_MAX) ? SCREEN_MAX : screen_width;
    cfg.screen_height = (screen_height > SCREEN_MAX) ? SCREEN_MAX : screen_height;
  end

endmodule

// ===== rtl/core/bmp565_in_reg.sv =====
// ---------------------------------------------------------------------------
// BMP565 input register
// Captures one request and holds it until the parser consumes it.
// ---------------------------------------------------------------------------
module bmp565_in_reg
  import bmp565_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] file_byte,
  input  logic       first_byte,
  input  logic       take,
  output logic       stage_valid,
  output logic [7:0] stage_byte,
  output logic       stage_first
);

  assign in_ready = !stage_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte  <= file_byte;
      stage_first <= first_byte;
    end
  end

endmodule

// ===== rtl/core/bmp565_parser.sv =====
// ---------------------------------------------------------------------------
// BMP565 parser
// Header decoding, offset skip, pixel assembly, row padding and cropping.
// ---------------------------------------------------------------------------
`include "bmp24_to_rgb565_stream_core_defines.svh"

module bmp565_parser
  import bmp565_pkg::*;
#(
  parameter int unsigned DIM_BITS = 16
)
(
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic [7:0] byte_in,
  input  logic       first,
  input  cfg_t       cfg,
  output logic       res_valid,
  output result_t    res
);

  localparam int unsigned POS_BITS = ((DIM_BITS > 15) ? DIM_BITS : 16) + 2;

  phase_t                     phase, phase_next, phase_cur;
  logic [5:0]                 hdr_idx, hdr_idx_next, hdr_cur;
  logic [31:0]                word, word_next, word_cur, word_shift;
  logic [31:0]                offset, offset_next;
  logic [31:0]                skip_left, skip_left_next;
  logic [DIM_BITS-1:0]        width, width_next;
  logic [DIM_BITS-1:0]        height, height_next;
  logic [DIM_BITS-1:0]        row, row_next;
  logic [DIM_BITS-1:0]        col, col_next;
  logic [1:0]                 byte_in_pixel, byte_in_pixel_next;
  logic [1:0]                 pad_left, pad_left_next;
  logic [7:0]                 blue, blue_next;
  logic [7:0]                 green, green_next;
  logic signed [POS_BITS-1:0] sx, sx_next;
  logic signed [POS_BITS-1:0] sy, sy_next;
  logic signed [POS_BITS-1:0] xo_ext, yo_ext, sw_ext, sh_ext;
  logic                       origin_bad, on_screen, last_col, last;

  always_comb begin
    xo_ext = {{(POS_BITS-16){cfg.x_origin[15]}}, cfg.x_origin};
    yo_ext = {{(POS_BITS-16){cfg.y_origin[15]}}, cfg.y_origin};
    sw_ext = {{(POS_BITS-SCREEN_BITS){1'b0}}, cfg.screen_width};
    sh_ext = {{(POS_BITS-SCREEN_BITS){1'b0}}, cfg.screen_height};
    origin_bad = (xo_ext >= sw_ext) || (yo_ext >= sh_ext);
    on_screen  = !sx[POS_BITS-1] && (sx < sw_ext) && !sy[POS_BITS-1] && (sy < sh_ext);
    last_col   = ((DIM_BITS+1)'(col) + 1'b1) == (DIM_BITS+1)'(width);
    last       = last_col && (((DIM_BITS+1)'(row) + 1'b1) == (DIM_BITS+1)'(height));
    phase_cur  = first ? PH_HEADER : phase;
    hdr_cur    = first ? 6'd0 : hdr_idx;
    word_cur   = first ? 32'd0 : word;
    word_shift = {byte_in, word_cur[31:8]};
  end

  always_comb begin
    phase_next         = phase;
    hdr_idx_next       = hdr_idx;
    word_next          = word;
    offset_next        = offset;
    skip_left_next     = skip_left;
    width_next         = width;
    height_next        = height;
    row_next           = row;
    col_next           = col;
    byte_in_pixel_next = byte_in_pixel;
    pad_left_next      = pad_left;
    blue_next          = blue;
    green_next         = green;
    sx_next            = sx;
    sy_next            = sy;
    res_valid          = 1'b0;
    res                = '0;
    if (go) begin
      if (first) begin
        phase_next         = PH_HEADER;
        offset_next        = '0;
        width_next         = '0;
        height_next        = '0;
        row_next           = '0;
        col_next           = '0;
        byte_in_pixel_next = '0;
        pad_left_next      = '0;
        blue_next          = '0;
        green_next         = '0;
      end
      unique case (phase_cur)
        PH_HEADER: begin
          word_next    = word_shift;
          hdr_idx_next = hdr_cur + 6'd1;
          if (hdr_cur == IDX_ORIGIN && origin_bad) begin
            res_valid  = 1'b1;
            res.kind   = KIND_OFF_SCREEN;
            phase_next = PH_IDLE;
          end else if (hdr_cur == IDX_SIG && word_shift[31:16] != BMP_SIGNATURE) begin
            res_valid  = 1'b1;
            res.kind   = KIND_BAD_SIG;
            phase_next = PH_IDLE;
          end else if ((hdr_cur == IDX_PLANES && word_shift[31:16] != BMP_PLANES) ||
                       (hdr_cur == IDX_DEPTH && word_shift[31:16] != BMP_DEPTH) ||
                       (hdr_cur == IDX_COMPR && word_shift != 32'd0)) begin
            res_valid  = 1'b1;
            res.kind   = KIND_BAD_FORMAT;
            phase_next = PH_IDLE;
          end else if (hdr_cur == IDX_OFFSET) begin
            offset_next = word_shift;
          end else if (hdr_cur == IDX_WIDTH) begin
            width_next = word_shift[DIM_BITS-1:0];
          end else if (hdr_cur == IDX_HEIGHT) begin
            height_next = word_shift[DIM_BITS-1:0];
          end else if (hdr_cur == IDX_COMPR) begin
            row_next           = '0;
            col_next           = '0;
            byte_in_pixel_next = '0;
            pad_left_next      = '0;
            sx_next            = xo_ext;
            sy_next            = yo_ext + POS_BITS'(height) - POS_BITS'(1);
            skip_left_next     = offset - HDR_BYTES;
            if (width == '0 || height == '0) begin
              phase_next = PH_IDLE;
            end else if (offset <= HDR_BYTES) begin
              phase_next = PH_PIXEL;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          skip_left_next = skip_left - 32'd1;
          if (skip_left == 32'd1) begin
            phase_next = PH_PIXEL;
          end
        end
        PH_PAD: begin
          pad_left_next = pad_left - 2'd1;
          if (pad_left == 2'd1) begin
            phase_next = PH_PIXEL;
          end
        end
        PH_PIXEL: begin
          case (byte_in_pixel)
            2'd0: begin
              blue_next          = byte_in;
              byte_in_pixel_next = 2'd1;
            end
            2'd1: begin
              green_next         = byte_in;
              byte_in_pixel_next = 2'd2;
            end
            default: begin
              byte_in_pixel_next = 2'd0;
              if (on_screen) begin
                res_valid      = 1'b1;
                res.kind       = KIND_PIXEL;
                res.pixel_x    = sx[PIX_BITS-1:0];
                res.pixel_y    = sy[PIX_BITS-1:0];
                res.color      = rgb565(blue, green, byte_in);
                res.image_done = last;
              end
              if (last) begin
                phase_next = PH_IDLE;
              end else if (last_col) begin
                col_next      = '0;
                row_next      = row + 1'b1;
                pad_left_next = width[1:0];
                sx_next       = xo_ext;
                sy_next       = sy - POS_BITS'(1);
                phase_next    = (width[1:0] != 2'd0) ? PH_PAD : PH_PIXEL;
              end else begin
                col_next = col + 1'b1;
                sx_next  = sx + POS_BITS'(1);
              end
            end
          endcase
        end
        PH_IDLE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      hdr_idx       <= '0;
      byte_in_pixel <= '0;
      pad_left      <= '0;
    end else begin
      phase         <= phase_next;
      hdr_idx       <= hdr_idx_next;
      byte_in_pixel <= byte_in_pixel_next;
      pad_left      <= pad_left_next;
    end
  end

  always_ff @(posedge clk) begin
    word      <= word_next;
    offset    <= offset_next;
    skip_left <= skip_left_next;
    width     <= width_next;
    height    <= height_next;
    row       <= row_next;
    col       <= col_next;
    blue      <= blue_next;
    green     <= green_next;
    sx        <= sx_next;
    sy        <= sy_next;
  end

  `BMP565_ASSERT_NOW(a_pad_nonzero, clk, rst, phase == PH_PAD, pad_left != 2'd0, "Pad phase with no pad bytes left.")
  `BMP565_ASSERT_NOW(a_skip_nonzero, clk, rst, phase == PH_SKIP, skip_left != 32'd0, "Skip phase with no bytes left.")
  `BMP565_ASSERT_NEXT(a_error_stops, clk, rst, go && res_valid && res.kind != KIND_PIXEL, phase == PH_IDLE, "Parser kept running after an error.")
  `BMP565_ASSERT_NOW(a_result_phase, clk, rst, go && res_valid && !first, phase == PH_PIXEL || phase == PH_HEADER, "Result from a phase that gives none.")

endmodule

// ===== rtl/core/bmp565_out_reg.sv =====
// ---------------------------------------------------------------------------
// BMP565 output register
// Holds one result until the consumer takes it.
// ---------------------------------------------------------------------------
module bmp565_out_reg
  import bmp565_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  logic    res_valid,
  input  result_t res_in,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t res_out,
  output logic    free
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      res_out <= res_in;
    end
  end

endmodule

// ===== rtl/core/bmp24_to_rgb565_stream_core.sv =====
// ---------------------------------------------------------------------------
// BMP24 to RGB565 stream core
// Decodes a 24-bit uncompressed BMP byte stream into cropped RGB565 pixels.
// ---------------------------------------------------------------------------
// Channel  Handshake             Payload
// in       in_valid / in_ready   file_byte, first_byte
// out      out_valid / out_ready kind, pixel_x, pixel_y, color, image_done
// cfg      cfg_write             cfg_index, cfg_data
//
// One request is taken every cycle while in_ready is high; any result passes through the input and output registers.
// The parser updates its state from the input register into the output register.
// Reset restores the default screen setup and restarts the header parser.
// A stalled result holds the parser; in_ready falls once the input register is full too.
// ---------------------------------------------------------------------------
module bmp24_to_rgb565_stream_core
  import bmp565_pkg::*;
#(
  parameter int unsigned DIM_BITS = 16
)
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          file_byte,
  input  logic                first_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          kind,
  output logic [PIX_BITS-1:0] pixel_x,
  output logic [PIX_BITS-1:0] pixel_y,
  output logic [15:0]         color,
  output logic                image_done,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  cfg_t       cfg;
  result_t    res, res_out;
  logic       res_valid;
  logic       stage_valid, stage_first, out_free, go;
  logic [7:0] stage_byte;

  assign go = stage_valid && out_free;

  bmp565_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bmp565_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .file_byte   (file_byte),
    .first_byte  (first_byte),
    .take        (go),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte),
    .stage_first (stage_first)
  );

  bmp565_parser #(
    .DIM_BITS (DIM_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .byte_in   (stage_byte),
    .first     (stage_first),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  bmp565_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (go),
    .res_valid (res_valid),
    .res_in    (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (res_out),
    .free      (out_free)
  );

  assign kind       = res_out.kind;
  assign pixel_x    = res_out.pixel_x;
  assign pixel_y    = res_out.pixel_y;
  assign color      = res_out.color;
  assign image_done = res_out.image_done;

endmodule
